// ----- hw/rtl/irc_pkg.sv -----
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types and constants of the idle-framed receiver with CRC-8 check
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int unsigned MAX_FRAME = 128;

  localparam logic [7:0] HDR0     = 8'h47;
  localparam logic [7:0] HDR1     = 8'h4D;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [7:0] IDLE_LIMIT_RST = 8'd5;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_IDLE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RELEASE = 2'd2
  } irc_mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_HDR_ERR = 2'd2
  } irc_status_t;

  typedef struct packed {
    logic        frame_done;
    irc_status_t frame_status;
    logic [7:0]  frame_length;
    logic [7:0]  command_byte;
    logic        byte_accepted;
  } irc_result_t;

endpackage

// ----- hw/rtl/irc_intf.sv -----
// ----------------------------------------------------------------------------
// irc_intf
// Valid/ready channels for receiver items and frame results
// ----------------------------------------------------------------------------
interface irc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface irc_out_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic [1:0] frame_status;
  logic [7:0] frame_length;
  logic [7:0] command_byte;
  logic       byte_accepted;

  modport source (output valid, output frame_done, output frame_status,
                  output frame_length, output command_byte,
                  output byte_accepted, input ready);
  modport sink   (input valid, input frame_done, input frame_status,
                  input frame_length, input command_byte,
                  input byte_accepted, output ready);
endinterface

// ----- hw/rtl/irc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// irc_cfg_regs
// APB-style register port holding the idle limit
// ----------------------------------------------------------------------------
module irc_cfg_regs
  import irc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [7:0]            idle_limit
);

  logic [7:0] idle_limit_r;
  logic       reg_sel;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (reg_sel == REG_IDLE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r <= IDLE_LIMIT_RST;
    end else if (wr_en) begin
      idle_limit_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == REG_IDLE_LIMIT) begin
      cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, idle_limit_r};
    end
  end

  assign idle_limit = idle_limit_r;

endmodule

// ----- hw/rtl/irc_frame_core.sv -----
// ----------------------------------------------------------------------------
// irc_frame_core
// Frame state and single-step update: bytes, idle timing, header and CRC check
// ----------------------------------------------------------------------------
module irc_frame_core
  import irc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic [1:0]  item_mode,
  input  logic [7:0]  item_byte,
  input  logic [7:0]  idle_limit,
  output irc_result_t result
);

  logic       frame_pending_r, frame_pending_nxt;
  logic       byte_seen_r, byte_seen_nxt;
  logic [7:0] idle_count_r, idle_count_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_crc_r, running_crc_nxt;
  logic [7:0] last_byte_r, last_byte_nxt;
  logic       header_match_r, header_match_nxt;
  logic [7:0] captured_command_r, captured_command_nxt;
  logic [7:0] idle_inc;
  irc_mode_t  mode;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign mode     = irc_mode_t'(item_mode);
  assign idle_inc = idle_count_r + 8'd1;

  always_comb begin
    frame_pending_nxt    = frame_pending_r;
    byte_seen_nxt        = byte_seen_r;
    idle_count_nxt       = idle_count_r;
    byte_count_nxt       = byte_count_r;
    running_crc_nxt      = running_crc_r;
    last_byte_nxt        = last_byte_r;
    header_match_nxt     = header_match_r;
    captured_command_nxt = captured_command_r;
    result               = '0;
    if (item_valid) begin
      unique case (mode)
        MODE_BYTE: begin
          if (!frame_pending_r && (byte_count_r < 8'(MAX_FRAME_LEN))) begin
            if (byte_count_r == 8'd0) begin
              running_crc_nxt  = 8'd0;
              header_match_nxt = (item_byte == HDR0);
            end else begin
              running_crc_nxt = crc8_step(running_crc_r, last_byte_r);
              if (byte_count_r == 8'd1) begin
                header_match_nxt = header_match_r && (item_byte == HDR1);
              end else if (byte_count_r == 8'd2) begin
                captured_command_nxt = item_byte;
              end
            end
            last_byte_nxt        = item_byte;
            byte_count_nxt       = byte_count_r + 8'd1;
            idle_count_nxt       = 8'd0;
            byte_seen_nxt        = 1'b1;
            result.byte_accepted = 1'b1;
          end
        end
        MODE_TICK: begin
          idle_count_nxt = idle_inc;
          if (byte_seen_r && (idle_inc > idle_limit)) begin
            result.frame_done   = 1'b1;
            result.frame_length = byte_count_r;
            result.command_byte = (byte_count_r >= 8'd3) ? captured_command_r : 8'd0;
            if ((byte_count_r < 8'd2) || !header_match_r) begin
              result.frame_status = STATUS_HDR_ERR;
            end else if (running_crc_r != last_byte_r) begin
              result.frame_status = STATUS_CRC_ERR;
            end else begin
              result.frame_status = STATUS_OK;
            end
            frame_pending_nxt    = 1'b1;
            byte_seen_nxt        = 1'b0;
            idle_count_nxt       = 8'd0;
            byte_count_nxt       = 8'd0;
            running_crc_nxt      = 8'd0;
            last_byte_nxt        = 8'd0;
            header_match_nxt     = 1'b0;
            captured_command_nxt = 8'd0;
          end
        end
        MODE_RELEASE: begin
          frame_pending_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pending_r    <= 1'b0;
      byte_seen_r        <= 1'b0;
      idle_count_r       <= 8'd0;
      byte_count_r       <= 8'd0;
      running_crc_r      <= 8'd0;
      last_byte_r        <= 8'd0;
      header_match_r     <= 1'b0;
      captured_command_r <= 8'd0;
    end else begin
      frame_pending_r    <= frame_pending_nxt;
      byte_seen_r        <= byte_seen_nxt;
      idle_count_r       <= idle_count_nxt;
      byte_count_r       <= byte_count_nxt;
      running_crc_r      <= running_crc_nxt;
      last_byte_r        <= last_byte_nxt;
      header_match_r     <= header_match_nxt;
      captured_command_r <= captured_command_nxt;
    end
  end

  a_seen_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    byte_seen_r |-> !frame_pending_r)
    else $error("open frame while a frame is pending");

  a_seen_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    byte_seen_r == (byte_count_r != 8'd0))
    else $error("byte_seen out of step with byte count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= 8'(MAX_FRAME_LEN))
    else $error("byte count past frame limit");

  a_done_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && result.frame_done) |=> (frame_pending_r && (byte_count_r == 8'd0)))
    else $error("ended frame not held pending");

endmodule

// ----- hw/rtl/idle_framed_uart_receiver_crc8_core.sv -----
// ----------------------------------------------------------------------------
// idle_framed_uart_receiver_crc8_core
// UART byte framing by idle timeout with header and CRC-8 check
// ----------------------------------------------------------------------------
// in_ch carries one item per transfer: a received byte (mode 0), a 1 ms tick
// (mode 1) or a software release of the pending frame (mode 2).
// out_ch returns exactly one result per item, in order: byte_accepted for
// bytes, and frame_done with status, length and command byte on the tick
// that ends a frame.
// Items pass an input register, then the frame logic writes the output
// register, and one item is taken every cycle while results are drained.
// When out_ch stalls, the output register holds its result and the input
// register takes one more item; in_ch.ready drops only when both are full.
// idle_limit is written through the cfg_ APB port at byte address 0
// (reset value 5); write it only while no items are in flight.
// Reset (rst_n low, synchronous) empties both registers, clears the frame
// state and leaves no frame pending.
// ----------------------------------------------------------------------------
module idle_framed_uart_receiver_crc8_core
  import irc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  irc_in_if.sink                in_ch,
  irc_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  irc_result_t out_res_r;
  irc_result_t step_res;
  logic [7:0]  idle_limit;
  logic        out_free;
  logic        advance;
  logic        in_xfer;

  irc_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .idle_limit (idle_limit)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  irc_frame_core #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .item_mode  (s1_mode_r),
    .item_byte  (s1_byte_r),
    .idle_limit (idle_limit),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r <= in_ch.mode;
      s1_byte_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_done    = out_res_r.frame_done;
  assign out_ch.frame_status  = out_res_r.frame_status;
  assign out_ch.frame_length  = out_res_r.frame_length;
  assign out_ch.command_byte  = out_res_r.command_byte;
  assign out_ch.byte_accepted = out_res_r.byte_accepted;

  a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("input register lost an item during a stall");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_free |-> in_ch.ready)
    else $error("input refused while output side can advance");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the idle-framed receiver with CRC-8 check
// ----------------------------------------------------------------------------
// Drives bytes, ticks and releases over the valid/ready input channel. A
// frame predictor inside the bench tracks idle count, header and CRC and
// queues the expected result of each transfer. Every result is compared
// field by field. A short table of directed items comes first. Random
// segments follow, each with its own idle limit, two per handshake pressure.
// ----------------------------------------------------------------------------
module tb;
  import irc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_IDLE_LIMIT = CFG_ADDR_W'(4 * REG_IDLE_LIMIT);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = CFG_ADDR_W'(4);
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_ITEMS   = 50;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  data;
    bit          fill_crc;
    bit          typed;
    irc_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  irc_in_if  in_ch ();
  irc_out_if out_ch ();

  idle_framed_uart_receiver_crc8_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // frame predictor state
  logic       rx_pending;
  logic       rx_seen;
  logic [7:0] rx_idle;
  logic [7:0] rx_count;
  logic [7:0] rx_crc;
  logic [7:0] rx_last;
  logic       rx_hdr_ok;
  logic [7:0] rx_cmd;
  logic [7:0] rx_limit;

  irc_result_t frame_results[$];
  dir_row_t    dir_rows[$];

  int send_idle;
  int recv_idle;
  int n_items;
  int n_err;
  int n_ok;
  int n_crc_err;
  int n_hdr_err;
  int n_refused;
  int n_limits;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void frame_clear();
    rx_seen   = 1'b0;
    rx_idle   = 8'd0;
    rx_count  = 8'd0;
    rx_crc    = 8'd0;
    rx_last   = 8'd0;
    rx_hdr_ok = 1'b0;
    rx_cmd    = 8'd0;
  endfunction

  function automatic irc_result_t frame_step(input logic [1:0] m, input logic [7:0] d);
    irc_result_t r;
    r = '0;
    case (m)
      MODE_BYTE: begin
        if (!rx_pending && rx_count < MAX_FRAME) begin
          if (rx_count == 8'd0) begin
            rx_crc    = 8'd0;
            rx_hdr_ok = (d == HDR0);
          end else begin
            rx_crc = crc8_next(rx_crc, rx_last);
            if (rx_count == 8'd1) rx_hdr_ok = rx_hdr_ok && (d == HDR1);
            else if (rx_count == 8'd2) rx_cmd = d;
          end
          rx_last  = d;
          rx_count = rx_count + 8'd1;
          rx_idle  = 8'd0;
          rx_seen  = 1'b1;
          r.byte_accepted = 1'b1;
        end
      end
      MODE_TICK: begin
        rx_idle = rx_idle + 8'd1;
        if (rx_seen && rx_idle > rx_limit) begin
          r.frame_done   = 1'b1;
          r.frame_length = rx_count;
          r.command_byte = (rx_count >= 8'd3) ? rx_cmd : 8'd0;
          if (rx_count < 8'd2 || !rx_hdr_ok) r.frame_status = STATUS_HDR_ERR;
          else if (rx_crc != rx_last) r.frame_status = STATUS_CRC_ERR;
          else r.frame_status = STATUS_OK;
          rx_pending = 1'b1;
          frame_clear();
        end
      end
      MODE_RELEASE: begin
        rx_pending = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic irc_result_t mk_res(input logic done, input irc_status_t st,
                                         input logic [7:0] len, input logic [7:0] cmd,
                                         input logic acc);
    irc_result_t r;
    r.frame_done    = done;
    r.frame_status  = st;
    r.frame_length  = len;
    r.command_byte  = cmd;
    r.byte_accepted = acc;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] m, input logic [7:0] d,
                                  input bit fill, input bit typed, input irc_result_t res);
    dir_row_t row;
    row.mode     = m;
    row.data     = d;
    row.fill_crc = fill;
    row.typed    = typed;
    row.res      = res;
    dir_rows.push_back(row);
  endfunction

  // one input transfer; returns at the accepting edge
  task automatic send_item(input logic [1:0] m, input logic [7:0] d,
                           input bit typed, input irc_result_t tres);
    irc_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = frame_step(m, d);
    frame_results.push_back(typed ? tres : r);
    n_items++;
    if (m == MODE_BYTE && !r.byte_accepted) n_refused++;
    if (r.frame_done) begin
      case (r.frame_status)
        STATUS_OK:      n_ok++;
        STATUS_CRC_ERR: n_crc_err++;
        default:        n_hdr_err++;
      endcase
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 8'($urandom), 1'b0, '0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= a;
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (a == ADDR_IDLE_LIMIT) rx_limit = v[7:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_check_limit();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_IDLE_LIMIT;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {24'd0, rx_limit}) begin
      n_err++;
      $display("%0t: idle_limit read expected %0d actual %0d", $time, rx_limit, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_frame(input int len, input bit good_hdr, input bit good_crc);
    logic [7:0] b;
    int lim;
    lim = (rx_limit < 8'd3) ? int'(rx_limit) : 3;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(3) == 0) send_ticks($urandom_range(lim));
      if ($urandom_range(19) == 0) send_item(MODE_UNUSED, 8'($urandom), 1'b0, '0);
      if ($urandom_range(29) == 0) send_item(MODE_RELEASE, 8'($urandom), 1'b0, '0);
      if (i == len - 1 && len >= 2 && good_crc) b = crc8_next(rx_crc, rx_last);
      else if (i == 0) b = good_hdr ? HDR0 : 8'($urandom);
      else if (i == 1) b = good_hdr ? HDR1 : 8'($urandom);
      else b = 8'($urandom);
      send_item(MODE_BYTE, b, 1'b0, '0);
    end
    send_ticks(int'(rx_limit) + 1 + $urandom_range(2));
    repeat ($urandom_range(2)) send_item(MODE_BYTE, 8'($urandom), 1'b0, '0);
    if ($urandom_range(9) != 0) send_item(MODE_RELEASE, 8'($urandom), 1'b0, '0);
  endtask

  task automatic run_segment(input int target);
    int stop;
    int k;
    stop = n_items + target;
    while (n_items < stop) begin
      k = $urandom_range(99);
      if (k < 62) begin
        send_frame($urandom_range(8, 1), $urandom_range(9) != 0, $urandom_range(4) != 0);
      end else if (k < 65) begin
        send_frame($urandom_range(135, 120), 1'b1, 1'b1);
      end else if (k < 80) begin
        send_frame($urandom_range(3, 1), $urandom_range(1), $urandom_range(1));
      end else begin
        repeat ($urandom_range(6, 1)) send_item(2'($urandom), 8'($urandom), 1'b0, '0);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    irc_result_t got;
    irc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.frame_done    = out_ch.frame_done;
      got.frame_status  = irc_status_t'(out_ch.frame_status);
      got.frame_length  = out_ch.frame_length;
      got.command_byte  = out_ch.command_byte;
      got.byte_accepted = out_ch.byte_accepted;
      if (frame_results.size() == 0) begin
        n_err++;
        $display("%0t: result with nothing expected: done %0b status %0d len %0d cmd %02h acc %0b",
                 $time, got.frame_done, got.frame_status, got.frame_length,
                 got.command_byte, got.byte_accepted);
      end else begin
        want = frame_results.pop_front();
        if (got.frame_done !== want.frame_done || got.frame_status !== want.frame_status ||
            got.frame_length !== want.frame_length ||
            got.command_byte !== want.command_byte ||
            got.byte_accepted !== want.byte_accepted) begin
          n_err++;
          $display("%0t: expected done %0b status %0d len %0d cmd %02h acc %0b", $time,
                   want.frame_done, want.frame_status, want.frame_length,
                   want.command_byte, want.byte_accepted);
          $display("%0t: actual   done %0b status %0d len %0d cmd %02h acc %0b", $time,
                   got.frame_done, got.frame_status, got.frame_length,
                   got.command_byte, got.byte_accepted);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles without any transfer
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall = 0;
      else stall++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] limits [6];
    logic [7:0] d;
    irc_result_t r_none;
    irc_result_t r_acc;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_BYTE;
    in_ch.data_byte = 8'd0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    rst_n           = 1'b0;
    send_idle       = 18;
    recv_idle       = 83;
    n_items = 0; n_err = 0; n_ok = 0; n_crc_err = 0; n_hdr_err = 0;
    n_refused = 0; n_limits = 1;
    rx_limit   = IDLE_LIMIT_RST;
    rx_pending = 1'b0;
    frame_clear();

    r_none = mk_res(1'b0, STATUS_OK, 8'd0, 8'd0, 1'b0);
    r_acc  = mk_res(1'b0, STATUS_OK, 8'd0, 8'd0, 1'b1);
    add_row(MODE_TICK, 8'h00, 1'b0, 1'b1, r_none);
    add_row(MODE_RELEASE, 8'hff, 1'b0, 1'b1, r_none);
    add_row(MODE_UNUSED, 8'hff, 1'b0, 1'b1, r_none);
    add_row(MODE_BYTE, HDR0, 1'b0, 1'b1, r_acc);
    add_row(MODE_BYTE, HDR1, 1'b0, 1'b1, r_acc);
    add_row(MODE_BYTE, 8'ha5, 1'b0, 1'b1, r_acc);
    add_row(MODE_BYTE, 8'h00, 1'b1, 1'b1, r_acc);
    repeat (5) add_row(MODE_TICK, 8'h00, 1'b0, 1'b1, r_none);
    add_row(MODE_TICK, 8'hff, 1'b0, 1'b0, r_none);
    add_row(MODE_BYTE, 8'h00, 1'b0, 1'b1, r_none);
    add_row(MODE_RELEASE, 8'h00, 1'b0, 1'b1, r_none);
    add_row(MODE_BYTE, 8'hff, 1'b0, 1'b1, r_acc);
    repeat (5) add_row(MODE_TICK, 8'h00, 1'b0, 1'b1, r_none);
    add_row(MODE_TICK, 8'h00, 1'b0, 1'b1,
            mk_res(1'b1, STATUS_HDR_ERR, 8'd1, 8'd0, 1'b0));
    add_row(MODE_RELEASE, 8'h00, 1'b0, 1'b1, r_none);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_check_limit();
    foreach (dir_rows[i]) begin
      d = dir_rows[i].fill_crc ? crc8_next(rx_crc, rx_last) : dir_rows[i].data;
      send_item(dir_rows[i].mode, d, dir_rows[i].typed, dir_rows[i].res);
    end

    limits[0] = 8'd0;
    limits[1] = 8'd254;
    limits[2] = 8'd2;
    limits[3] = 8'd7;
    limits[4] = 8'd1;
    limits[5] = 8'($urandom_range(12));
    for (int s = 0; s < 6; s++) begin
      wait_idle();
      case (s / 2)
        0: begin send_idle = 18; recv_idle = 83; end
        1: begin send_idle = 83; recv_idle = 18; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      cfg_write(ADDR_UNMAPPED, $urandom);
      cfg_write(ADDR_IDLE_LIMIT, {24'd0, limits[s]});
      cfg_check_limit();
      n_limits++;
      // idle count wraps while no byte is held
      if (limits[s] == 8'd254) send_ticks(260);
      run_segment(SEG_ITEMS);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    $display("covered %0d items, %0d idle-limit settings, %0d bytes refused", n_items,
             n_limits, n_refused);
    $display("frames ended: %0d good, %0d crc error, %0d header error; %0d mismatches",
             n_ok, n_crc_err, n_hdr_err, n_err);
    if (n_err == 0 && frame_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/irc_pkg.sv
hw/rtl/irc_intf.sv
hw/rtl/irc_cfg_regs.sv
hw/rtl/irc_frame_core.sv
hw/rtl/idle_framed_uart_receiver_crc8_core.sv
tb/tb.sv
